// ===== sv/kgrs_pkg.sv =====
// Shared types and constants for the keypoint grid radius search block.
package kgrs_pkg;

  // Input word command codes.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_OUTSIDE = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_MATCH   = 3'd3;
  localparam logic [2:0] ST_NOMATCH = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  // Configuration register indexes and reset value.
  localparam logic CFG_SCALE_X = 1'b0;
  localparam logic CFG_SCALE_Y = 1'b1;
  localparam logic [15:0] SCALE_RESET = 16'd6554;

  // Most matches one query delivers.
  localparam int RESULT_LIMIT = 64;

  // Result key index as it leaves the block.
  typedef logic [9:0] key_out_t;

  // Insert cell from the rounded scaled coordinate.
  typedef struct packed {
    logic       in_grid;
    logic [7:0] cx;
    logic [7:0] cy;
  } ins_cell_t;

  // Clamped query cell rectangle.
  typedef struct packed {
    logic       ok;
    logic [7:0] x0;
    logic [7:0] x1;
    logic [7:0] y0;
    logic [7:0] y1;
  } rect_t;

endpackage

// ===== sv/kgrs_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module kgrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/kgrs_bounds.sv =====
// Scaled coordinate products and the insert cell and query rectangle built from them.
module kgrs_bounds #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 48
) (
  input  logic                   clk,
  input  logic [15:0]            px,
  input  logic [15:0]            py,
  input  logic [15:0]            rad,
  input  logic [15:0]            sx,
  input  logic [15:0]            sy,
  output kgrs_pkg::ins_cell_t    ins,
  output kgrs_pkg::rect_t        rect
);

  logic [31:0]        ins_x_r, ins_y_r;
  logic signed [33:0] lo_x_r, lo_y_r;
  logic [32:0]        hi_x_r, hi_y_r;
  logic signed [16:0] dlo_x, dlo_y;
  logic [16:0]        dhi_x, dhi_y;
  logic [32:0]        rnd_x, rnd_y;
  logic [33:0]        cil_x, cil_y;
  logic [13:0]        hx, hy;
  logic signed [13:0] lx, ly;

  assign dlo_x = $signed({1'b0, px}) - $signed({1'b0, rad});
  assign dlo_y = $signed({1'b0, py}) - $signed({1'b0, rad});
  assign dhi_x = {1'b0, px} + {1'b0, rad};
  assign dhi_y = {1'b0, py} + {1'b0, rad};

  // One register stage after the multipliers.
  always_ff @(posedge clk) begin
    ins_x_r <= 32'(px) * 32'(sx);
    ins_y_r <= 32'(py) * 32'(sy);
    lo_x_r  <= 34'(dlo_x) * $signed({18'd0, sx});
    lo_y_r  <= 34'(dlo_y) * $signed({18'd0, sy});
    hi_x_r  <= 33'(dhi_x) * 33'(sx);
    hi_y_r  <= 33'(dhi_y) * 33'(sy);
  end

  // Insert cell: round half up, then range check.
  assign rnd_x = {1'b0, ins_x_r} + 33'(1 << 19);
  assign rnd_y = {1'b0, ins_y_r} + 33'(1 << 19);
  assign ins.in_grid = (rnd_x[32:20] < 13'(GRID_COLS)) && (rnd_y[32:20] < 13'(GRID_ROWS));
  assign ins.cx = rnd_x[27:20];
  assign ins.cy = rnd_y[27:20];

  // Query rectangle: floor of the low edge, ceiling of the high edge, clamped.
  assign lx    = lo_x_r[33:20];
  assign ly    = lo_y_r[33:20];
  assign cil_x = {1'b0, hi_x_r} + 34'((1 << 20) - 1);
  assign cil_y = {1'b0, hi_y_r} + 34'((1 << 20) - 1);
  assign hx    = cil_x[33:20];
  assign hy    = cil_y[33:20];

  assign rect.ok = (lx[13] || (lx[12:0] < 13'(GRID_COLS))) &&
                   (ly[13] || (ly[12:0] < 13'(GRID_ROWS)));
  assign rect.x0 = lx[13] ? 8'd0 : lx[7:0];
  assign rect.y0 = ly[13] ? 8'd0 : ly[7:0];
  assign rect.x1 = (hx > 14'(GRID_COLS - 1)) ? 8'(GRID_COLS - 1) : hx[7:0];
  assign rect.y1 = (hy > 14'(GRID_ROWS - 1)) ? 8'(GRID_ROWS - 1) : hy[7:0];

endmodule

// ===== sv/keypoint_grid_radius_search.sv =====
// Top level of the keypoint grid radius search: sequencer and its memories.
//
// Input words carry a command: clear, insert or query. One word is taken at a
// time; in_ready is high only while the sequencer is idle. Command 3 is dropped.
// Other words yield result words on the out_ channel, the final one with last.
// An insert runs through up to five sequencer steps, through the key and fill
// memories, and then returns to idle; its result word is registered in the
// last step.
// A query runs its setup steps, then walks each visited grid cell through the
// fill memory and each filed key in those cells through the slot and key
// memories in turn; it closes in an end step, or early past the match limit.
// A clear sweeps the fill memory one cell per cycle, all GRID_COLS*GRID_ROWS
// cells (3072 by default), then loads its result.
// Reset runs the same sweep, with no result; in_ready stays low until it ends.
// Configuration writes are taken in any cycle on the cfg_ channel.
// Results pass through one output register; while the receiver stalls the
// sequencer waits at its next word to emit until the register is taken.
module keypoint_grid_radius_search #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 48,
  parameter int MAX_KEYS  = 1024,
  parameter int CELL_CAP  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic [15:0]       in_point_x,
  input  logic [15:0]       in_point_y,
  input  logic [2:0]        in_octave,
  input  logic [15:0]       in_radius,
  input  logic [2:0]        in_min_level,
  input  logic signed [3:0] in_max_level,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [9:0]        out_key_index,
  output logic [2:0]        out_status,
  output logic              out_truncated,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int CW     = GRID_COLS > 1 ? $clog2(GRID_COLS) : 1;
  localparam int RW     = GRID_ROWS > 1 ? $clog2(GRID_ROWS) : 1;
  localparam int CELLS  = GRID_COLS * GRID_ROWS;
  localparam int CEW    = CELLS > 1 ? $clog2(CELLS) : 1;
  localparam int SDEPTH = CELLS * CELL_CAP;
  localparam int SAW    = SDEPTH > 1 ? $clog2(SDEPTH) : 1;
  localparam int KW     = $clog2(MAX_KEYS);
  localparam int FW     = $clog2(CELL_CAP + 1);
  localparam int KEYD_W = 35;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MUL, S_ICHK, S_IADR, S_IFC, S_RECT, S_CELL,
    S_FADR, S_FCHK, S_SWAIT, S_SLOT, S_KEY, S_END, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [15:0] px_r, px_nxt, py_r, py_nxt, rad_r, rad_nxt;
  logic [2:0]  oct_r, oct_nxt, minl_r, minl_nxt;
  logic [3:0]  maxl_r, maxl_nxt;
  logic [15:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [KW:0] kcnt_r, kcnt_nxt;
  logic [CEW-1:0] cell_r, cell_nxt, clr_r, clr_nxt;
  logic [CW-1:0]  ix_r, ix_nxt, x1_r, x1_nxt;
  logic [RW-1:0]  iy_r, iy_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic [FW-1:0]  fill_r, fill_nxt, j_r, j_nxt;
  logic [6:0]     found_r, found_nxt;
  logic [KW-1:0]  pend_r, pend_nxt, rkey_r, rkey_nxt;
  logic [2:0]     rstat_r, rstat_nxt;
  logic           clr_emit_r, clr_emit_nxt;
  logic           ovalid_r, ovalid_nxt, otrunc_r, otrunc_nxt, olast_r, olast_nxt;
  logic [9:0]     okey_r, okey_nxt;
  logic [2:0]     ostat_r, ostat_nxt;

  // Memory ports.
  logic              key_we;
  logic [KEYD_W-1:0] key_rdata;
  logic              fill_we;
  logic [CEW-1:0]    fill_waddr;
  logic [FW-1:0]     fill_wdata, fill_rdata;
  logic              slot_we;
  logic [SAW-1:0]    slot_addr;
  logic [FW-1:0]     slot_off;
  logic [KW-1:0]     slot_rdata;

  kgrs_pkg::ins_cell_t ins;
  kgrs_pkg::rect_t     rect;

  logic        out_free, in_acc;
  logic [2:0]  k_lvl;
  logic [15:0] k_x, k_y;
  logic [16:0] dx, dy, adx, ady;
  logic        lvl_ok, hit;
  state_t      nc_state;
  logic [CW-1:0] nc_ix;
  logic [RW-1:0] nc_iy;

  assign out_free  = !ovalid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  kgrs_bounds #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_bounds (
    .clk (clk), .px (px_r), .py (py_r), .rad (rad_r), .sx (sx_r), .sy (sy_r),
    .ins (ins), .rect (rect)
  );

  // Key store: octave, x and y of each key.
  kgrs_ram #(.WIDTH(KEYD_W), .DEPTH(MAX_KEYS)) u_key_ram (
    .clk (clk), .we (key_we), .waddr (kcnt_r[KW-1:0]),
    .wdata ({oct_r, px_r, py_r}), .raddr (slot_rdata), .rdata (key_rdata)
  );

  // Per-cell fill counts.
  kgrs_ram #(.WIDTH(FW), .DEPTH(CELLS)) u_fill_ram (
    .clk (clk), .we (fill_we), .waddr (fill_waddr), .wdata (fill_wdata),
    .raddr (cell_r), .rdata (fill_rdata)
  );

  // Per-cell slot lists of key indexes.
  kgrs_ram #(.WIDTH(KW), .DEPTH(SDEPTH)) u_slot_ram (
    .clk (clk), .we (slot_we), .waddr (slot_addr), .wdata (rkey_r),
    .raddr (slot_addr), .rdata (slot_rdata)
  );

  assign slot_off   = (state_r == S_IFC) ? fill_rdata : j_r;
  assign slot_addr  = SAW'(cell_r) * SAW'(CELL_CAP) + SAW'(slot_off);
  assign fill_waddr = (state_r == S_CLR) ? clr_r : cell_r;

  // Match test of the key read for the current slot.
  assign k_lvl  = key_rdata[34:32];
  assign k_x    = key_rdata[31:16];
  assign k_y    = key_rdata[15:0];
  assign dx     = {1'b0, k_x} - {1'b0, px_r};
  assign dy     = {1'b0, k_y} - {1'b0, py_r};
  assign adx    = dx[16] ? (17'd0 - dx) : dx;
  assign ady    = dy[16] ? (17'd0 - dy) : dy;
  assign lvl_ok = (k_lvl >= minl_r) && (maxl_r[3] || ({1'b0, k_lvl} <= maxl_r));
  assign hit    = lvl_ok && (adx < {1'b0, rad_r}) && (ady < {1'b0, rad_r});

  // Step to the next cell: rows inner, columns outer.
  always_comb begin
    nc_ix    = ix_r;
    nc_iy    = iy_r;
    nc_state = S_END;
    if (iy_r < y1_r) begin
      nc_iy    = iy_r + 1'b1;
      nc_state = S_CELL;
    end else if (ix_r < x1_r) begin
      nc_ix    = ix_r + 1'b1;
      nc_iy    = y0_r;
      nc_state = S_CELL;
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    rad_nxt      = rad_r;
    oct_nxt      = oct_r;
    minl_nxt     = minl_r;
    maxl_nxt     = maxl_r;
    sx_nxt       = sx_r;
    sy_nxt       = sy_r;
    kcnt_nxt     = kcnt_r;
    cell_nxt     = cell_r;
    clr_nxt      = clr_r;
    ix_nxt       = ix_r;
    iy_nxt       = iy_r;
    x1_nxt       = x1_r;
    y0_nxt       = y0_r;
    y1_nxt       = y1_r;
    fill_nxt     = fill_r;
    j_nxt        = j_r;
    found_nxt    = found_r;
    pend_nxt     = pend_r;
    rkey_nxt     = rkey_r;
    rstat_nxt    = rstat_r;
    clr_emit_nxt = clr_emit_r;
    ovalid_nxt   = out_ready ? 1'b0 : ovalid_r;
    okey_nxt     = okey_r;
    ostat_nxt    = ostat_r;
    otrunc_nxt   = otrunc_r;
    olast_nxt    = olast_r;
    key_we       = 1'b0;
    fill_we      = 1'b0;
    fill_wdata   = '0;
    slot_we      = 1'b0;

    // Configuration writes.
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == kgrs_pkg::CFG_SCALE_X) begin
        sx_nxt = cfg_data;
      end else begin
        sy_nxt = cfg_data;
      end
    end

    case (state_r)
      S_CLR: begin
        fill_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CEW'(CELLS - 1)) begin
          rkey_nxt  = '0;
          rstat_nxt = kgrs_pkg::ST_CLEARED;
          state_nxt = clr_emit_r ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_command;
          px_nxt    = in_point_x;
          py_nxt    = in_point_y;
          rad_nxt   = in_radius;
          oct_nxt   = in_octave;
          minl_nxt  = in_min_level;
          maxl_nxt  = in_max_level;
          found_nxt = '0;
          case (in_command)
            kgrs_pkg::CMD_CLEAR: begin
              kcnt_nxt     = '0;
              clr_nxt      = '0;
              clr_emit_nxt = 1'b1;
              state_nxt    = S_CLR;
            end
            kgrs_pkg::CMD_INSERT, kgrs_pkg::CMD_QUERY: state_nxt = S_MUL;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        if (cmd_r == kgrs_pkg::CMD_QUERY) begin
          state_nxt = S_RECT;
        end else if (kcnt_r >= (KW + 1)'(MAX_KEYS)) begin
          rkey_nxt  = '0;
          rstat_nxt = kgrs_pkg::ST_FULL;
          state_nxt = S_OUT;
        end else begin
          key_we    = 1'b1;
          kcnt_nxt  = kcnt_r + 1'b1;
          rkey_nxt  = kcnt_r[KW-1:0];
          state_nxt = S_ICHK;
        end
      end
      S_ICHK: begin
        if (!ins.in_grid) begin
          rstat_nxt = kgrs_pkg::ST_OUTSIDE;
          state_nxt = S_OUT;
        end else begin
          cell_nxt  = CEW'(ins.cx[CW-1:0]) * CEW'(GRID_ROWS) + CEW'(ins.cy[RW-1:0]);
          state_nxt = S_IADR;
        end
      end
      S_IADR: state_nxt = S_IFC;
      S_IFC: begin
        if (fill_rdata >= FW'(CELL_CAP)) begin
          rstat_nxt = kgrs_pkg::ST_FULL;
        end else begin
          slot_we    = 1'b1;
          fill_we    = 1'b1;
          fill_wdata = fill_rdata + 1'b1;
          rstat_nxt  = kgrs_pkg::ST_STORED;
        end
        state_nxt = S_OUT;
      end
      S_RECT: begin
        ix_nxt = rect.x0[CW-1:0];
        iy_nxt = rect.y0[RW-1:0];
        x1_nxt = rect.x1[CW-1:0];
        y0_nxt = rect.y0[RW-1:0];
        y1_nxt = rect.y1[RW-1:0];
        state_nxt = rect.ok ? S_CELL : S_END;
      end
      S_CELL: begin
        cell_nxt  = CEW'(ix_r) * CEW'(GRID_ROWS) + CEW'(iy_r);
        state_nxt = S_FADR;
      end
      S_FADR: state_nxt = S_FCHK;
      S_FCHK: begin
        fill_nxt = fill_rdata;
        j_nxt    = '0;
        if (fill_rdata == '0) begin
          ix_nxt    = nc_ix;
          iy_nxt    = nc_iy;
          state_nxt = nc_state;
        end else begin
          state_nxt = S_SWAIT;
        end
      end
      S_SWAIT: state_nxt = S_SLOT;
      S_SLOT:  state_nxt = S_KEY;
      S_KEY: begin
        if (hit && found_r == 7'(kgrs_pkg::RESULT_LIMIT)) begin
          // A further match after the limit: close with the truncation flag.
          if (out_free) begin
            ovalid_nxt = 1'b1;
            okey_nxt   = kgrs_pkg::key_out_t'(pend_r);
            ostat_nxt  = kgrs_pkg::ST_MATCH;
            otrunc_nxt = 1'b1;
            olast_nxt  = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (!hit || found_r == '0 || out_free) begin
          if (hit) begin
            if (found_r != '0) begin
              ovalid_nxt = 1'b1;
              okey_nxt   = kgrs_pkg::key_out_t'(pend_r);
              ostat_nxt  = kgrs_pkg::ST_MATCH;
              otrunc_nxt = 1'b0;
              olast_nxt  = 1'b0;
            end
            pend_nxt  = slot_rdata;
            found_nxt = found_r + 1'b1;
          end
          if (({1'b0, j_r} + 1'b1) < {1'b0, fill_r}) begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_SWAIT;
          end else begin
            ix_nxt    = nc_ix;
            iy_nxt    = nc_iy;
            state_nxt = nc_state;
          end
        end
      end
      S_END: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          otrunc_nxt = 1'b0;
          olast_nxt  = 1'b1;
          if (found_r != '0) begin
            okey_nxt  = kgrs_pkg::key_out_t'(pend_r);
            ostat_nxt = kgrs_pkg::ST_MATCH;
          end else begin
            okey_nxt  = '0;
            ostat_nxt = kgrs_pkg::ST_NOMATCH;
          end
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          okey_nxt   = kgrs_pkg::key_out_t'(rkey_r);
          ostat_nxt  = rstat_r;
          otrunc_nxt = 1'b0;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_r      <= '0;
      clr_emit_r <= 1'b0;
      kcnt_r     <= '0;
      sx_r       <= kgrs_pkg::SCALE_RESET;
      sy_r       <= kgrs_pkg::SCALE_RESET;
      ovalid_r   <= 1'b0;
      found_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      clr_emit_r <= clr_emit_nxt;
      kcnt_r     <= kcnt_nxt;
      sx_r       <= sx_nxt;
      sy_r       <= sy_nxt;
      ovalid_r   <= ovalid_nxt;
      found_r    <= found_nxt;
    end
    cmd_r   <= cmd_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    rad_r   <= rad_nxt;
    oct_r   <= oct_nxt;
    minl_r  <= minl_nxt;
    maxl_r  <= maxl_nxt;
    cell_r  <= cell_nxt;
    ix_r    <= ix_nxt;
    iy_r    <= iy_nxt;
    x1_r    <= x1_nxt;
    y0_r    <= y0_nxt;
    y1_r    <= y1_nxt;
    fill_r  <= fill_nxt;
    j_r     <= j_nxt;
    pend_r  <= pend_nxt;
    rkey_r  <= rkey_nxt;
    rstat_r <= rstat_nxt;
    okey_r  <= okey_nxt;
    ostat_r <= ostat_nxt;
    otrunc_r <= otrunc_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid     = ovalid_r;
  assign out_key_index = okey_r;
  assign out_status    = ostat_r;
  assign out_truncated = otrunc_r;
  assign out_last      = olast_r;

endmodule

// ===== sv/kgrs_checker.sv =====
// Port-level checks of the keypoint grid radius search, bound to the top level.
module kgrs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] out_key_index,
  input logic [2:0] out_status,
  input logic       out_truncated,
  input logic       out_last
);

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_index) &&
    $stable(out_status) && $stable(out_last) && $stable(out_truncated))
    else $error("stalled result word changed");

  // Truncation only marks the closing match of a query.
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_last && out_status == kgrs_pkg::ST_MATCH)
    else $error("truncation flag on a word that does not close a query");

  // No-match and cleared results always close their command with key index zero.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == kgrs_pkg::ST_NOMATCH ||
                  out_status == kgrs_pkg::ST_CLEARED) |-> out_last && out_key_index == '0)
    else $error("no-match or cleared word malformed");

  // Only matches may leave last low.
  a_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == kgrs_pkg::ST_MATCH)
    else $error("non-final word that is not a match");

  // Nothing comes out right after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind keypoint_grid_radius_search kgrs_checker u_kgrs_checker (
  .clk (clk), .rst_n (rst_n), .out_valid (out_valid), .out_ready (out_ready),
  .out_key_index (out_key_index), .out_status (out_status),
  .out_truncated (out_truncated), .out_last (out_last)
);
